FILE: rtl/delta_list_timer_queue_core_assert.svh
// Assertion macros for the delta-list timer queue core.
// Included by the top level; needs no other file.
`ifndef DELTA_LIST_TIMER_QUEUE_CORE_ASSERT_SVH
`define DELTA_LIST_TIMER_QUEUE_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DLTQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer queue: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define DLTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer queue: next-cycle check failed");

`endif

FILE: rtl/dltq_pkg.sv
// Shared types and codes of the delta-list timer queue.
// Used by the shared arithmetic unit and the top level; depends on nothing.
package dltq_pkg;

    // Fixed widths of the input and result fields.
    localparam int ID_BITS       = 5;
    localparam int TICKS_IN_BITS = 16;

    // At most this many expired slots are reported for one tick.
    localparam int MAX_RESULTS = 32;
    localparam int CNT_BITS    = 6;

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_SCHEDULE = 2'd0;
    localparam t_mode MODE_CANCEL   = 2'd1;
    localparam t_mode MODE_TICK     = 2'd2;

    typedef logic [1:0] t_status;
    localparam t_status STATUS_OK            = 2'd0;
    localparam t_status STATUS_NOT_QUEUED    = 2'd1;
    localparam t_status STATUS_ALREADY_QUEUED = 2'd2;

    typedef logic [1:0] t_alu_op;
    localparam t_alu_op ALU_SUB       = 2'd0;
    localparam t_alu_op ALU_SUB_FLOOR = 2'd1;
    localparam t_alu_op ALU_ADD_SAT   = 2'd2;

    // One result word.
    typedef struct packed {
        t_status              status;
        logic                 expired_valid;
        logic [ID_BITS-1:0]   expired_id;
        logic                 last;
    } t_result;

endpackage

FILE: rtl/delta_list_timer_queue_core.sv
// Top level of the delta-list timer queue: sequencer, head and queued flags.
// Depends on dltq_pkg, dltq_ram, dltq_alu and delta_list_timer_queue_core_assert.svh.
//
// Channel  | Handshake                  | Payload
// ---------+----------------------------+------------------------------------------
// command  | start, busy (accept: start | i_mode, i_timer_id, i_ticks
//          | high while busy low)       |
// result   | o_result_strobe, one cycle | o_status, o_expired_valid, o_expired_id,
//          | per word, never stalled    | o_last
//
// Schedule and cancel walk the list and read one slot per cycle from the link and delta
// memories. A tick decrements the head and reports each expired slot in turn; errors,
// a tick on an empty list and the unused mode answer straight from idle.
// Each result word is registered and appears in the cycle after the step that forms it;
// busy falls with the final one.
// Synchronous reset empties the list at once; no clearing pass is needed.
`include "delta_list_timer_queue_core_assert.svh"

module delta_list_timer_queue_core #(
    parameter int NUM_SLOTS = 32,
    parameter int TICK_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    input  dltq_pkg::t_mode                      i_mode,
    input  logic [dltq_pkg::ID_BITS-1:0]         i_timer_id,
    input  logic [dltq_pkg::TICKS_IN_BITS-1:0]   i_ticks,
    output logic                                 busy,
    output logic                                 o_result_strobe,
    output dltq_pkg::t_status                    o_status,
    output logic                                 o_expired_valid,
    output logic [dltq_pkg::ID_BITS-1:0]         o_expired_id,
    output logic                                 o_last
);

    import dltq_pkg::*;

    localparam int AW = $clog2(NUM_SLOTS);
    localparam int SW = $clog2(NUM_SLOTS + 1);
    localparam logic [SW-1:0]        LIST_END = SW'(NUM_SLOTS);
    localparam logic [TICK_BITS-1:0] TICK_MAX = '1;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SCH_CMP  = 4'd1;
    localparam logic [3:0] S_SCH_W1   = 4'd2;
    localparam logic [3:0] S_SCH_W2   = 4'd3;
    localparam logic [3:0] S_CAN_ID   = 4'd4;
    localparam logic [3:0] S_CAN_WALK = 4'd5;
    localparam logic [3:0] S_CAN_SUCC = 4'd6;
    localparam logic [3:0] S_TK_DEC   = 4'd7;
    localparam logic [3:0] S_TK_CHK   = 4'd8;
    localparam logic [3:0] S_TK_LAST  = 4'd9;

    // Memory address of a slot; the end marker maps to entry zero.
    function automatic logic [AW-1:0] f_addr(input logic [SW-1:0] slot);
        logic [AW-1:0] addr;
        addr = (slot == LIST_END) ? '0 : slot[AW-1:0];
        return addr;
    endfunction

    // Builds one result word; the expired slot reads as zero when not valid.
    function automatic t_result f_result(input t_status st, input logic vld,
                                         input logic [SW-1:0] slot, input logic lst);
        t_result res;
        res.status        = st;
        res.expired_valid = vld;
        res.expired_id    = vld ? ID_BITS'(slot) : '0;
        res.last          = lst;
        return res;
    endfunction

    logic [3:0]           r_state, n_state;
    logic [SW-1:0]        r_head, n_head;
    logic [NUM_SLOTS-1:0] r_queued, n_queued;
    logic [SW-1:0]        r_id, n_id;
    logic [TICK_BITS-1:0] r_t, n_t;
    logic [SW-1:0]        r_prev, n_prev;
    logic [SW-1:0]        r_cur, n_cur;
    logic [SW-1:0]        r_succ, n_succ;
    logic [TICK_BITS-1:0] r_dcur, n_dcur;
    logic [CNT_BITS-1:0]  r_cnt, n_cnt;
    logic                 r_out_valid, n_out_valid;
    t_result              r_res, n_res;

    logic [AW-1:0]        rd_addr;
    logic                 next_we;
    logic [AW-1:0]        next_waddr;
    logic [SW-1:0]        next_wdata;
    logic [SW-1:0]        next_rdata;
    logic                 delta_we;
    logic [AW-1:0]        delta_waddr;
    logic [TICK_BITS-1:0] delta_wdata;
    logic [TICK_BITS-1:0] delta_rdata;

    t_alu_op              alu_op;
    logic [TICK_BITS-1:0] alu_a;
    logic [TICK_BITS-1:0] alu_b;
    logic [TICK_BITS-1:0] alu_res;
    logic                 alu_borrow;

    logic [SW-1:0]            in_slot;
    logic                     in_id_ok;
    logic                     in_queued;
    logic [TICKS_IN_BITS-1:0] ticks_clamp;
    logic [TICK_BITS-1:0]     ticks_sat;

    // Link and delta storage of the slots.
    dltq_ram #(.WIDTH(SW), .DEPTH(NUM_SLOTS)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (next_we),
        .i_waddr (next_waddr),
        .i_wdata (next_wdata),
        .i_raddr (rd_addr),
        .o_rdata (next_rdata)
    );

    dltq_ram #(.WIDTH(TICK_BITS), .DEPTH(NUM_SLOTS)) u_delta_ram (
        .i_clk   (i_clk),
        .i_we    (delta_we),
        .i_waddr (delta_waddr),
        .i_wdata (delta_wdata),
        .i_raddr (rd_addr),
        .o_rdata (delta_rdata)
    );

    // The one arithmetic unit that every step of the sequencer shares.
    dltq_alu #(.WIDTH(TICK_BITS)) u_alu (
        .i_op     (alu_op),
        .i_a      (alu_a),
        .i_b      (alu_b),
        .o_res    (alu_res),
        .o_borrow (alu_borrow)
    );

    // Command decode: slot range, queued flag and the clamped tick count.
    assign in_slot   = SW'(i_timer_id);
    assign in_id_ok  = 32'(i_timer_id) < 32'(NUM_SLOTS);
    assign in_queued = in_id_ok && r_queued[f_addr(in_slot)];

    always_comb begin
        if (i_ticks == '0) begin
            ticks_clamp = TICKS_IN_BITS'(1);
        end else if (i_ticks > TICKS_IN_BITS'(TICK_MAX)) begin
            ticks_clamp = TICKS_IN_BITS'(TICK_MAX);
        end else begin
            ticks_clamp = i_ticks;
        end
    end

    assign ticks_sat = TICK_BITS'(ticks_clamp);

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_queued    = r_queued;
        n_id        = r_id;
        n_t         = r_t;
        n_prev      = r_prev;
        n_cur       = r_cur;
        n_succ      = r_succ;
        n_dcur      = r_dcur;
        n_cnt       = r_cnt;
        n_out_valid = 1'b0;
        n_res       = f_result(STATUS_OK, 1'b0, LIST_END, 1'b1);

        rd_addr     = f_addr(r_cur);
        next_we     = 1'b0;
        next_waddr  = f_addr(r_id);
        next_wdata  = r_cur;
        delta_we    = 1'b0;
        delta_waddr = f_addr(r_id);
        delta_wdata = r_t;

        alu_op      = ALU_SUB;
        alu_a       = r_t;
        alu_b       = delta_rdata;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_id   = in_slot;
                    n_t    = ticks_sat;
                    n_prev = LIST_END;
                    n_cur  = r_head;
                    case (i_mode)
                        MODE_SCHEDULE: begin
                            if (!in_id_ok) begin
                                n_out_valid = 1'b1;
                            end else if (in_queued) begin
                                n_out_valid = 1'b1;
                                n_res = f_result(STATUS_ALREADY_QUEUED, 1'b0, LIST_END, 1'b1);
                            end else begin
                                rd_addr = f_addr(r_head);
                                n_state = (r_head == LIST_END) ? S_SCH_W1 : S_SCH_CMP;
                            end
                        end
                        MODE_CANCEL: begin
                            if (!in_queued) begin
                                n_out_valid = 1'b1;
                                n_res = f_result(STATUS_NOT_QUEUED, 1'b0, LIST_END, 1'b1);
                            end else begin
                                rd_addr = f_addr(in_slot);
                                n_state = S_CAN_ID;
                            end
                        end
                        MODE_TICK: begin
                            if (r_head == LIST_END) begin
                                n_out_valid = 1'b1;
                            end else begin
                                rd_addr = f_addr(r_head);
                                n_state = S_TK_DEC;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end

            // Walk past every slot whose delta does not exceed the remaining count.
            S_SCH_CMP: begin
                if (!alu_borrow) begin
                    n_t     = alu_res;
                    n_prev  = r_cur;
                    n_cur   = next_rdata;
                    rd_addr = f_addr(next_rdata);
                    if (next_rdata == LIST_END) begin
                        n_state = S_SCH_W1;
                    end
                end else begin
                    n_dcur  = delta_rdata;
                    n_state = S_SCH_W1;
                end
            end

            // Link the new slot to its successor and shorten the successor's delta.
            S_SCH_W1: begin
                next_we     = 1'b1;
                next_waddr  = f_addr(r_id);
                next_wdata  = r_cur;
                alu_a       = r_dcur;
                alu_b       = r_t;
                delta_we    = (r_cur != LIST_END);
                delta_waddr = f_addr(r_cur);
                delta_wdata = alu_res;
                n_state     = S_SCH_W2;
            end

            // Store the new slot's delta and hook it behind its predecessor.
            S_SCH_W2: begin
                delta_we    = 1'b1;
                delta_waddr = f_addr(r_id);
                delta_wdata = r_t;
                n_queued[f_addr(r_id)] = 1'b1;
                if (r_prev == LIST_END) begin
                    n_head = r_id;
                end else begin
                    next_we    = 1'b1;
                    next_waddr = f_addr(r_prev);
                    next_wdata = r_id;
                end
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end

            // The cancelled slot's link and delta are now read back.
            S_CAN_ID: begin
                n_succ = next_rdata;
                n_dcur = delta_rdata;
                if (r_head == r_id) begin
                    rd_addr = f_addr(next_rdata);
                    n_state = S_CAN_SUCC;
                end else begin
                    n_cur   = r_head;
                    rd_addr = f_addr(r_head);
                    n_state = S_CAN_WALK;
                end
            end

            // Search for the slot that links to the cancelled one.
            S_CAN_WALK: begin
                if (next_rdata == r_id) begin
                    n_prev  = r_cur;
                    rd_addr = f_addr(r_succ);
                    n_state = S_CAN_SUCC;
                end else begin
                    n_cur   = next_rdata;
                    rd_addr = f_addr(next_rdata);
                end
            end

            // Unlink and fold the cancelled delta into the successor.
            S_CAN_SUCC: begin
                alu_op      = ALU_ADD_SAT;
                alu_a       = delta_rdata;
                alu_b       = r_dcur;
                delta_we    = (r_succ != LIST_END);
                delta_waddr = f_addr(r_succ);
                delta_wdata = alu_res;
                if (r_prev == LIST_END) begin
                    n_head = r_succ;
                end else begin
                    next_we    = 1'b1;
                    next_waddr = f_addr(r_prev);
                    next_wdata = r_succ;
                end
                n_queued[f_addr(r_id)] = 1'b0;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end

            // Decrement the head, holding at zero, and pop it when it reaches zero.
            S_TK_DEC: begin
                alu_op = ALU_SUB_FLOOR;
                alu_a  = delta_rdata;
                alu_b  = TICK_BITS'(1);
                if (alu_res != '0) begin
                    delta_we    = 1'b1;
                    delta_waddr = f_addr(r_head);
                    delta_wdata = alu_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_id   = r_head;
                    n_head = next_rdata;
                    n_cnt  = CNT_BITS'(1);
                    n_queued[f_addr(r_head)] = 1'b0;
                    if (next_rdata == LIST_END) begin
                        n_out_valid = 1'b1;
                        n_res       = f_result(STATUS_OK, 1'b1, r_head, 1'b1);
                        n_state     = S_IDLE;
                    end else begin
                        rd_addr = f_addr(next_rdata);
                        n_state = S_TK_CHK;
                    end
                end
            end

            // Report the pending slot; it is the last unless the new head expires within the result limit.
            S_TK_CHK: begin
                n_out_valid = 1'b1;
                if (delta_rdata == '0 && r_cnt < CNT_BITS'(MAX_RESULTS)) begin
                    n_res  = f_result(STATUS_OK, 1'b1, r_id, 1'b0);
                    n_id   = r_head;
                    n_head = next_rdata;
                    n_cnt  = r_cnt + CNT_BITS'(1);
                    n_queued[f_addr(r_head)] = 1'b0;
                    if (next_rdata == LIST_END) begin
                        n_state = S_TK_LAST;
                    end else begin
                        rd_addr = f_addr(next_rdata);
                    end
                end else begin
                    n_res   = f_result(STATUS_OK, 1'b1, r_id, 1'b1);
                    n_state = S_IDLE;
                end
            end

            S_TK_LAST: begin
                n_out_valid = 1'b1;
                n_res       = f_result(STATUS_OK, 1'b1, r_id, 1'b1);
                n_state     = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= LIST_END;
            r_queued    <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_queued    <= n_queued;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and result word registers.
    always_ff @(posedge i_clk) begin
        r_id   <= n_id;
        r_t    <= n_t;
        r_prev <= n_prev;
        r_cur  <= n_cur;
        r_succ <= n_succ;
        r_dcur <= n_dcur;
        r_res  <= n_res;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_result_strobe = r_out_valid;
    assign o_status        = r_res.status;
    assign o_expired_valid = r_res.expired_valid;
    assign o_expired_id    = r_res.expired_id;
    assign o_last          = r_res.last;

    // Every accepted command either starts a sequence or answers at once.
    `DLTQ_ASSERT_NEXT(a_accept_progress, i_clk, i_rst_n,
        start && !busy, busy || o_result_strobe)
    // A word that is not the final one is followed directly by another.
    `DLTQ_ASSERT_NEXT(a_burst_contiguous, i_clk, i_rst_n,
        o_result_strobe && !o_last, o_result_strobe)
    // Expiry words always report success.
    `DLTQ_ASSERT_SAME(a_expiry_ok, i_clk, i_rst_n,
        o_result_strobe && o_expired_valid, o_status == STATUS_OK)
    // Between commands the list is empty exactly when no slot is queued.
    `DLTQ_ASSERT_SAME(a_head_flags, i_clk, i_rst_n,
        r_state == S_IDLE, (r_head == LIST_END) == (r_queued == '0))

endmodule

FILE: rtl/dltq_ram.sv
// Single-port-write, single-port-read memory with registered read data.
// Holds the link and delta words of the timer slots; depends on nothing.
module dltq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/dltq_alu.sv
// Shared subtract, floored subtract and saturating add unit of the timer queue.
// Depends on dltq_pkg for the operation codes.
module dltq_alu #(
    parameter int WIDTH = 16
) (
    input  dltq_pkg::t_alu_op i_op,
    input  logic [WIDTH-1:0]  i_a,
    input  logic [WIDTH-1:0]  i_b,
    output logic [WIDTH-1:0]  o_res,
    output logic              o_borrow
);

    import dltq_pkg::*;

    logic [WIDTH:0] diff;
    logic [WIDTH:0] sum;

    assign diff = {1'b0, i_a} - {1'b0, i_b};
    assign sum  = {1'b0, i_a} + {1'b0, i_b};

    // The top bit of the difference is the borrow, that of the sum the carry.
    always_comb begin
        case (i_op)
            ALU_SUB: begin
                o_res    = diff[WIDTH-1:0];
                o_borrow = diff[WIDTH];
            end
            ALU_SUB_FLOOR: begin
                o_res    = diff[WIDTH] ? '0 : diff[WIDTH-1:0];
                o_borrow = diff[WIDTH];
            end
            ALU_ADD_SAT: begin
                o_res    = sum[WIDTH] ? '1 : sum[WIDTH-1:0];
                o_borrow = 1'b0;
            end
            default: begin
                o_res    = i_a;
                o_borrow = 1'b0;
            end
        endcase
    end

endmodule

FILE: sim/dltq_checker.sv
// Checker for the delta-list timer queue: keeps its own copy of the timer list,
// predicts every result word and compares it with what the core reports.
// Depends on dltq_pkg for the field types and the mode and status codes.
module dltq_checker #(
    parameter int NUM_SLOTS = 32,
    parameter int TICK_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic                               i_busy,
    input  dltq_pkg::t_mode                    i_mode,
    input  logic [dltq_pkg::ID_BITS-1:0]       i_timer_id,
    input  logic [dltq_pkg::TICKS_IN_BITS-1:0] i_ticks,
    input  logic                               i_result_strobe,
    input  dltq_pkg::t_status                  i_status,
    input  logic                               i_expired_valid,
    input  logic [dltq_pkg::ID_BITS-1:0]       i_expired_id,
    input  logic                               i_last,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import dltq_pkg::*;

    localparam int REF_BITS = $clog2(NUM_SLOTS) + 1;
    localparam int IDX_BITS = $clog2(NUM_SLOTS);
    typedef logic [REF_BITS-1:0] t_slot_ref;
    typedef logic [IDX_BITS-1:0] t_slot_idx;
    localparam t_slot_ref LIST_END = t_slot_ref'(NUM_SLOTS);
    localparam logic [TICK_BITS-1:0] TICK_MAX = '1;

    // Shadow copy of the timer list.
    t_slot_ref            list_head;
    t_slot_ref            slot_link  [NUM_SLOTS];
    logic [TICK_BITS-1:0] slot_delta [NUM_SLOTS];
    logic                 slot_queued[NUM_SLOTS];

    // Result words still to come, oldest first.
    t_result expected_words[$];
    int      failures = 0;

    // Array index of a slot reference that is known to name a queued slot.
    function automatic t_slot_idx slot_index(input t_slot_ref s);
        return s[IDX_BITS-1:0];
    endfunction

    // Insert a slot after every slot whose deadline is not later than its own.
    task automatic schedule_slot(input logic [ID_BITS-1:0] id,
                                 input logic [TICKS_IN_BITS-1:0] req,
                                 output t_status st);
        t_slot_ref   prev;
        t_slot_ref   cur;
        logic [31:0] remain;
        int          n;
        prev = LIST_END;
        cur  = list_head;
        n    = 0;
        if (int'(id) >= NUM_SLOTS) begin
            st = STATUS_OK;
            return;
        end
        if (slot_queued[id]) begin
            st = STATUS_ALREADY_QUEUED;
            return;
        end
        remain = (req == '0) ? 32'd1 : 32'(req);
        if (remain > 32'(TICK_MAX)) begin
            remain = 32'(TICK_MAX);
        end
        while (n < NUM_SLOTS && cur < LIST_END
               && 32'(slot_delta[slot_index(cur)]) <= remain) begin
            remain = remain - 32'(slot_delta[slot_index(cur)]);
            prev   = cur;
            cur    = slot_link[slot_index(cur)];
            n++;
        end
        if (prev == LIST_END) begin
            list_head = t_slot_ref'(id);
        end else begin
            slot_link[slot_index(prev)] = t_slot_ref'(id);
        end
        slot_link[id] = cur;
        if (cur < LIST_END) begin
            slot_delta[slot_index(cur)] = slot_delta[slot_index(cur)]
                                        - remain[TICK_BITS-1:0];
        end
        slot_delta[id]  = remain[TICK_BITS-1:0];
        slot_queued[id] = 1'b1;
        st = STATUS_OK;
    endtask

    // Unlink a slot and hand its delta on to its successor, saturating.
    task automatic cancel_slot(input logic [ID_BITS-1:0] id, output t_status st);
        t_slot_ref            prev;
        t_slot_ref            cur;
        t_slot_ref            succ;
        logic [TICK_BITS:0]   merged;
        int                   n;
        prev = LIST_END;
        cur  = list_head;
        n    = 0;
        if (int'(id) >= NUM_SLOTS || !slot_queued[id]) begin
            st = STATUS_NOT_QUEUED;
            return;
        end
        while (n < NUM_SLOTS && cur < LIST_END && cur != t_slot_ref'(id)) begin
            prev = cur;
            cur  = slot_link[slot_index(cur)];
            n++;
        end
        if (cur != t_slot_ref'(id)) begin
            st = STATUS_NOT_QUEUED;
            return;
        end
        succ = slot_link[id];
        if (prev == LIST_END) begin
            list_head = succ;
        end else begin
            slot_link[slot_index(prev)] = succ;
        end
        if (succ < LIST_END) begin
            merged = {1'b0, slot_delta[slot_index(succ)]} + {1'b0, slot_delta[id]};
            slot_delta[slot_index(succ)] = (merged > {1'b0, TICK_MAX})
                                         ? TICK_MAX : merged[TICK_BITS-1:0];
        end
        slot_queued[id] = 1'b0;
        st = STATUS_OK;
    endtask

    // One tick: decrement the head, then pop every slot that has run out, up to MAX_RESULTS.
    task automatic tick_list();
        t_slot_ref h;
        t_result   held;
        logic      holding;
        int        n;
        h       = list_head;
        holding = 1'b0;
        held    = '0;
        n       = 0;
        if (h < LIST_END && slot_delta[slot_index(h)] != '0) begin
            slot_delta[slot_index(h)] = slot_delta[slot_index(h)] - 1'b1;
        end
        while (n < MAX_RESULTS && h < LIST_END && slot_delta[slot_index(h)] == '0) begin
            list_head                  = slot_link[slot_index(h)];
            slot_queued[slot_index(h)] = 1'b0;
            if (holding) begin
                expected_words.push_back(held);
            end
            held    = '{status: STATUS_OK, expired_valid: 1'b1,
                        expired_id: h[ID_BITS-1:0], last: 1'b0};
            holding = 1'b1;
            h       = list_head;
            n++;
        end
        if (holding) begin
            held.last = 1'b1;
            expected_words.push_back(held);
        end else begin
            expected_words.push_back('{status: STATUS_OK, expired_valid: 1'b0,
                                       expired_id: '0, last: 1'b1});
        end
    endtask

    // Work out the words that one accepted command causes.
    task automatic predict_command(input t_mode mode, input logic [ID_BITS-1:0] id,
                                   input logic [TICKS_IN_BITS-1:0] ticks);
        t_status st;
        st = STATUS_OK;
        case (mode)
            MODE_SCHEDULE: schedule_slot(id, ticks, st);
            MODE_CANCEL:   cancel_slot(id, st);
            MODE_TICK:     tick_list();
            default:       st = STATUS_OK;
        endcase
        if (mode != MODE_TICK) begin
            expected_words.push_back('{status: st, expired_valid: 1'b0,
                                       expired_id: '0, last: 1'b1});
        end
    endtask

    // Report one field that differs; returns 1 on a mismatch.
    function automatic bit field_differs(input string name, input logic [7:0] want,
                                         input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Result words are checked before a command accepted at the same edge is predicted.
    always @(posedge i_clk) begin
        t_result want;
        bit      bad;
        if (!i_rst_n) begin
            list_head = LIST_END;
            for (int s = 0; s < NUM_SLOTS; s++) begin
                slot_queued[s] = 1'b0;
            end
            expected_words.delete();
        end else begin
            if (i_result_strobe) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual status %0d "
                             , $time, i_status,
                             "valid %0d id %0d last %0d",
                             i_expired_valid, i_expired_id, i_last);
                    failures++;
                end else begin
                    want = expected_words.pop_front();
                    bad  = field_differs("status", 8'(want.status), 8'(i_status))
                         | field_differs("expired_valid", 8'(want.expired_valid),
                                         8'(i_expired_valid))
                         | field_differs("expired_id", 8'(want.expired_id),
                                         8'(i_expired_id))
                         | field_differs("last", 8'(want.last), 8'(i_last));
                    if (bad) begin
                        failures++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                predict_command(i_mode, i_timer_id, i_ticks);
            end
        end
        o_pending    <= expected_words.size();
        o_fail_count <= failures;
    end

endmodule

FILE: sim/tb_delta_list_timer_queue_core.sv
// Testbench top for the delta-list timer queue core: clock, reset and commands.
// Depends on dltq_pkg, the core and dltq_checker, which predicts and compares.
module tb_delta_list_timer_queue_core;
    timeunit 1ns;
    timeprecision 1ps;
    import dltq_pkg::*;

    localparam int    NUM_SLOTS      = 32;
    localparam int    TICK_BITS      = 16;
    localparam int    STALL_LIMIT    = 2000;
    localparam t_mode MODE_NO_OP     = 2'd3;

    logic                     i_clk      = 1'b0;
    logic                     i_rst_n    = 1'b0;
    logic                     start      = 1'b0;
    t_mode                    i_mode     = MODE_SCHEDULE;
    logic [ID_BITS-1:0]       i_timer_id = '0;
    logic [TICKS_IN_BITS-1:0] i_ticks    = '0;
    logic                     busy;
    logic                     o_result_strobe;
    t_status                  o_status;
    logic                     o_expired_valid;
    logic [ID_BITS-1:0]       o_expired_id;
    logic                     o_last;
    int                       fail_count;
    int                       pending;
    int                       quiet_cycles = 0;
    int                       sender_idle_pct = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    delta_list_timer_queue_core #(
        .NUM_SLOTS(NUM_SLOTS),
        .TICK_BITS(TICK_BITS)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .i_mode(i_mode),
        .i_timer_id(i_timer_id),
        .i_ticks(i_ticks),
        .busy(busy),
        .o_result_strobe(o_result_strobe),
        .o_status(o_status),
        .o_expired_valid(o_expired_valid),
        .o_expired_id(o_expired_id),
        .o_last(o_last)
    );

    dltq_checker #(
        .NUM_SLOTS(NUM_SLOTS),
        .TICK_BITS(TICK_BITS)
    ) u_checker (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_busy(busy),
        .i_mode(i_mode),
        .i_timer_id(i_timer_id),
        .i_ticks(i_ticks),
        .i_result_strobe(o_result_strobe),
        .i_status(o_status),
        .i_expired_valid(o_expired_valid),
        .i_expired_id(o_expired_id),
        .i_last(o_last),
        .o_fail_count(fail_count),
        .o_pending(pending)
    );

    // Watchdog: end the run when neither a command nor a word moves for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_result_strobe) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Offer one command after a random idle gap and hold it until accepted.
    task automatic send_command(input t_mode mode, input logic [ID_BITS-1:0] id,
                                input logic [TICKS_IN_BITS-1:0] ticks);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(0, 99) < sender_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_mode     <= mode;
        i_timer_id <= id;
        i_ticks    <= ticks;
        do begin
            @(posedge i_clk);
        end while (busy);
    endtask

    // Stop sending until every predicted word has come back.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Random mix weighted toward short timers so that ticks expire slots often.
    task automatic run_random(input int count);
        int                       pick;
        t_mode                    mode;
        logic [ID_BITS-1:0]       id;
        logic [TICKS_IN_BITS-1:0] ticks;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            id   = ID_BITS'($urandom_range(0, NUM_SLOTS - 1));
            case ($urandom_range(0, 9))
                0:       ticks = '0;
                1:       ticks = TICKS_IN_BITS'($urandom());
                2:       ticks = TICKS_IN_BITS'($urandom_range(7, 60));
                default: ticks = TICKS_IN_BITS'($urandom_range(1, 6));
            endcase
            if (pick < 40) begin
                mode = MODE_SCHEDULE;
            end else if (pick < 58) begin
                mode = MODE_CANCEL;
            end else if (pick < 96) begin
                mode = MODE_TICK;
            end else begin
                mode = MODE_NO_OP;
            end
            if ($urandom_range(0, 99) < 3) begin
                drain_results();
            end
            send_command(mode, id, ticks);
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: ties, zero count, full count, errors, head, middle and tail cancels.
        sender_idle_pct = 38;
        send_command(MODE_SCHEDULE, 5'd0, 16'd0);
        send_command(MODE_SCHEDULE, 5'd31, 16'hFFFF);
        send_command(MODE_SCHEDULE, 5'd5, 16'd3);
        send_command(MODE_SCHEDULE, 5'd6, 16'd3);
        send_command(MODE_SCHEDULE, 5'd7, 16'd1);
        send_command(MODE_SCHEDULE, 5'd8, 16'd2);
        send_command(MODE_SCHEDULE, 5'd5, 16'd9);
        send_command(MODE_CANCEL, 5'd9, 16'd0);
        send_command(MODE_CANCEL, 5'd8, 16'd0);
        send_command(MODE_NO_OP, 5'd31, 16'hFFFF);
        send_command(MODE_TICK, 5'd0, 16'd0);
        send_command(MODE_TICK, 5'd31, 16'hAAAA);
        send_command(MODE_TICK, 5'd10, 16'h5555);
        send_command(MODE_CANCEL, 5'd5, 16'd0);
        send_command(MODE_SCHEDULE, 5'd10, 16'd2);
        send_command(MODE_SCHEDULE, 5'd11, 16'd4);
        send_command(MODE_CANCEL, 5'd10, 16'd0);
        repeat (4) send_command(MODE_TICK, 5'd0, 16'd0);
        send_command(MODE_CANCEL, 5'd31, 16'd0);
        send_command(MODE_TICK, 5'd0, 16'd0);
        drain_results();

        run_random(100);
        drain_results();

        sender_idle_pct = 59;
        run_random(100);
        drain_results();

        // Schedule every slot with the same short count and tick once; a slot still queued keeps its count.
        sender_idle_pct = 0;
        for (int s = 0; s < NUM_SLOTS; s++) begin
            send_command(MODE_SCHEDULE, ID_BITS'(s), 16'd1);
        end
        send_command(MODE_TICK, 5'd0, 16'd0);
        run_random(75);

        drain_results();
        repeat (NUM_SLOTS + 8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/dltq_pkg.sv
rtl/dltq_ram.sv
rtl/dltq_alu.sv
rtl/delta_list_timer_queue_core.sv
sim/dltq_checker.sv
sim/tb_delta_list_timer_queue_core.sv
